### sv/bmp_24bit_stream_writer_unit_macros.svh
// assertion helpers shared by the stream writer modules
`ifndef BMP_24BIT_STREAM_WRITER_UNIT_MACROS_SVH
`define BMP_24BIT_STREAM_WRITER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clock edge outside reset
`define BMP24_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// next-cycle implication
`define BMP24_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`else

`define BMP24_ASSERT_IMPLIES(label, clk, rst, cond, prop, msg)
`define BMP24_ASSERT_NEXT(label, clk, rst, cond, prop, msg)

`endif

`endif

### sv/bmp24_pkg.sv
package bmp24_pkg;

   localparam int unsigned COMP_W     = 17;
   localparam int unsigned DIM_W      = 14;
   localparam int unsigned RAW_W      = 30;
   localparam int unsigned ROWB_W     = 16;
   localparam int unsigned IDX_W      = 6;
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W     = 2;
   localparam int unsigned QCNT_W     = 3;

   localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(53);
   localparam logic [IDX_W-1:0] PIX_LAST = IDX_W'(2);

   localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(640);
   localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(480);

   localparam logic [RAW_W-1:0] HEADER_BYTES = RAW_W'(54);
   localparam logic [7:0]       INFO_BYTES   = 8'd40;
   localparam logic [15:0]      RESOLUTION   = 16'd2835;
   localparam logic [7:0]       BITS_PER_PIX = 8'd24;
   localparam logic [7:0]       MAGIC_B      = 8'h42;
   localparam logic [7:0]       MAGIC_M      = 8'h4D;

   // register indexes of the configuration port
   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } bmp24_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       frame_end;
   } bmp24_rsp_type;

   // one classified pixel, handed from front to back
   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       header;
      logic [1:0] pad;
      logic       frame_end;
   } bmp24_entry_type;

   // floor(v * 255 / 65536) mod 256, v * 255 done as shift and subtract
   function automatic logic [7:0] comp_to_byte(input logic [COMP_W-1:0] v);
      logic [COMP_W+7:0] prod;
      prod = {v, 8'd0} - {8'd0, v};
      return prod[23:16];
   endfunction

   // one byte of the 54-byte file and info header, little-endian fields
   function automatic logic [7:0] header_byte(input logic [IDX_W-1:0] idx,
                                              input logic [DIM_W-1:0] width,
                                              input logic [DIM_W-1:0] height,
                                              input logic [RAW_W-1:0] raw,
                                              input logic [RAW_W-1:0] size);
      logic [7:0] b;
      b = 8'd0;
      case (idx)
         IDX_W'(0):  b = MAGIC_B;
         IDX_W'(1):  b = MAGIC_M;
         IDX_W'(2):  b = size[7:0];
         IDX_W'(3):  b = size[15:8];
         IDX_W'(4):  b = size[23:16];
         IDX_W'(5):  b = {2'd0, size[29:24]};
         IDX_W'(10): b = HEADER_BYTES[7:0];
         IDX_W'(14): b = INFO_BYTES;
         IDX_W'(18): b = width[7:0];
         IDX_W'(19): b = {2'd0, width[13:8]};
         IDX_W'(22): b = height[7:0];
         IDX_W'(23): b = {2'd0, height[13:8]};
         IDX_W'(26): b = 8'd1;
         IDX_W'(28): b = BITS_PER_PIX;
         IDX_W'(34): b = raw[7:0];
         IDX_W'(35): b = raw[15:8];
         IDX_W'(36): b = raw[23:16];
         IDX_W'(37): b = {2'd0, raw[29:24]};
         IDX_W'(38), IDX_W'(42): b = RESOLUTION[7:0];
         IDX_W'(39), IDX_W'(43): b = RESOLUTION[15:8];
         default:    b = 8'd0;
      endcase
      return b;
   endfunction

endpackage

### sv/bmp24_front.sv
module bmp24_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   input  bmp24_pkg::bmp24_req_type     req_data,
   input  logic                         q_full,
   input  logic [bmp24_pkg::DIM_W-1:0]  frame_width,
   input  logic [bmp24_pkg::DIM_W-1:0]  frame_height,
   output logic                         q_push,
   output bmp24_pkg::bmp24_entry_type   q_entry
);
   import bmp24_pkg::*;

   logic [DIM_W-1:0] column_ff, column_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W:0]   column_next;
   logic [DIM_W:0]   row_next;
   logic             row_end;
   logic             frame_done;

   assign q_push      = req_push && !q_full;
   assign column_next = {1'b0, column_ff} + (DIM_W+1)'(1);
   assign row_next    = {1'b0, row_ff} + (DIM_W+1)'(1);
   assign row_end     = column_next >= {1'b0, frame_width};
   assign frame_done  = row_end && (row_next >= {1'b0, frame_height});

   always_comb begin
      q_entry.blue      = comp_to_byte(req_data.blue);
      q_entry.green     = comp_to_byte(req_data.green);
      q_entry.red       = comp_to_byte(req_data.red);
      q_entry.header    = (column_ff == '0) && (row_ff == '0);
      // 3 * width mod 4 padding works out to width mod 4
      q_entry.pad       = row_end ? frame_width[1:0] : 2'd0;
      q_entry.frame_end = frame_done;
   end

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (q_push) begin
         if (row_end) begin
            column_in = '0;
            row_in    = frame_done ? '0 : row_next[DIM_W-1:0];
         end else begin
            column_in = column_next[DIM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
      end else begin
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

### sv/bmp24_queue.sv
`include "bmp_24bit_stream_writer_unit_macros.svh"

module bmp24_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  bmp24_pkg::bmp24_entry_type  wr_entry,
   output logic                        full,
   input  logic                        pop,
   output bmp24_pkg::bmp24_entry_type  rd_entry,
   output logic                        empty
);
   import bmp24_pkg::*;

   bmp24_entry_type    mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push_ok;
   logic               pop_ok;

   assign full     = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign empty    = count_ff == '0;
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;
   assign rd_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `BMP24_ASSERT_IMPLIES(a_count_bound, clock, reset, 1'b1, count_ff <= QCNT_W'(QUEUE_DEPTH), "queue count past depth")
   `BMP24_ASSERT_IMPLIES(a_ptr_gap, clock, reset, !full, (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0], "queue pointers disagree with count")

endmodule

### sv/bmp24_back.sv
`include "bmp_24bit_stream_writer_unit_macros.svh"

module bmp24_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  bmp24_pkg::bmp24_entry_type   q_entry,
   output logic                         q_pop,
   input  logic [bmp24_pkg::DIM_W-1:0]  frame_width,
   input  logic [bmp24_pkg::DIM_W-1:0]  frame_height,
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output bmp24_pkg::bmp24_rsp_type     rsp_data
);
   import bmp24_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HEAD = 4'b0010,
      ST_PIX  = 4'b0100,
      ST_PAD  = 4'b1000
   } back_state_type;

   back_state_type   state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   bmp24_entry_type  entry_ff, entry_in;
   bmp24_rsp_type    out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic [ROWB_W-1:0] row_bytes;
   logic [ROWB_W-1:0] row_bytes_ff;
   logic [RAW_W-1:0]  raw_ff;
   logic [RAW_W-1:0]  size_ff;

   logic             adv;
   logic             emit;
   logic             last;
   logic [7:0]       byte_val;

   // padded row length, raw size and file size track the registers
   assign row_bytes = ROWB_W'(frame_width) + ROWB_W'({frame_width, 1'b0})
                      + ROWB_W'(frame_width[1:0]);

   always_ff @(posedge clock) begin
      row_bytes_ff <= row_bytes;
      raw_ff       <= RAW_W'(row_bytes_ff) * RAW_W'(frame_height);
      size_ff      <= raw_ff + HEADER_BYTES;
   end

   assign adv       = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      entry_in     = entry_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      q_pop        = 1'b0;
      emit         = 1'b0;
      last         = 1'b0;
      byte_val     = 8'd0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               entry_in = q_entry;
               idx_in   = '0;
               state_in = q_entry.header ? ST_HEAD : ST_PIX;
            end
         end
         ST_HEAD: begin
            if (adv) begin
               emit     = 1'b1;
               byte_val = header_byte(idx_ff, frame_width, frame_height, raw_ff, size_ff);
               if (idx_ff == HDR_LAST) begin
                  state_in = ST_PIX;
                  idx_in   = '0;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_PIX: begin
            if (adv) begin
               emit = 1'b1;
               // file order is blue, green, red
               if (idx_ff == '0) begin
                  byte_val = entry_ff.blue;
               end else if (idx_ff == IDX_W'(1)) begin
                  byte_val = entry_ff.green;
               end else begin
                  byte_val = entry_ff.red;
               end
               if (idx_ff == PIX_LAST) begin
                  if (entry_ff.pad != 2'd0) begin
                     state_in = ST_PAD;
                     idx_in   = '0;
                  end else begin
                     last = 1'b1;
                  end
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         ST_PAD: begin
            if (adv) begin
               emit = 1'b1;
               if (idx_ff == IDX_W'(entry_ff.pad) - IDX_W'(1)) begin
                  last = 1'b1;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         out_in.out_byte  = byte_val;
         out_in.run_last  = last;
         out_in.frame_end = last && entry_ff.frame_end;
         out_valid_in     = 1'b1;
      end

      // chain straight into the next entry so bytes keep flowing
      if (last) begin
         if (!q_empty) begin
            q_pop    = 1'b1;
            entry_in = q_entry;
            idx_in   = '0;
            state_in = q_entry.header ? ST_HEAD : ST_PIX;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      out_ff   <= out_in;
      idx_ff   <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `BMP24_ASSERT_IMPLIES(a_head_idx, clock, reset, state_ff == ST_HEAD, idx_ff <= HDR_LAST && entry_ff.header, "header index out of range")
   `BMP24_ASSERT_IMPLIES(a_pad_idx, clock, reset, state_ff == ST_PAD, entry_ff.pad != 2'd0 && idx_ff < IDX_W'(entry_ff.pad), "pad index out of range")

endmodule

### sv/bmp_24bit_stream_writer_unit.sv
// a pixel taken into an idle block passes the queue, entry and output registers
// before its first byte shows; one byte per cycle out while rsp_pop keeps up and
// the queue holds pixels, three per pixel plus the pad bytes at each row end and
// 54 header bytes before the first pixel of a frame; pixels are taken every cycle
// until the 4-entry pixel queue fills; reset (synchronous, active high): counters
// zero, queue and output empty, width 640 and height 480
`include "bmp_24bit_stream_writer_unit_macros.svh"

module bmp_24bit_stream_writer_unit (
   input  logic                         clock,
   input  logic                         reset,
   // pixel input beats
   input  logic                         req_push,
   output logic                         req_full,
   input  bmp24_pkg::bmp24_req_type     req_data,
   // file byte beats
   output logic                         rsp_empty,
   input  logic                         rsp_pop,
   output bmp24_pkg::bmp24_rsp_type     rsp_data,
   // register writes
   input  logic                         csr_we,
   input  logic                         csr_index,
   input  logic [bmp24_pkg::DIM_W-1:0]  csr_wdata
);
   import bmp24_pkg::*;

   // image size registers, read live by front and back
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;

   // front to queue
   logic            q_push;
   bmp24_entry_type q_wr_entry;
   logic            q_full;

   // queue to back
   logic            q_pop;
   bmp24_entry_type q_rd_entry;
   logic            q_empty;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  width_in  = csr_wdata;
            CSR_FRAME_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   // the input side stalls only when the pixel queue is full
   assign req_full = q_full;

   // front: converts components, tracks column and row, marks header, padding and frame end
   bmp24_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_data     (req_data),
      .q_full       (q_full),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .q_push       (q_push),
      .q_entry      (q_wr_entry)
   );

   // short queue decoupling classification from byte emission
   bmp24_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .full     (q_full),
      .pop      (q_pop),
      .rd_entry (q_rd_entry),
      .empty    (q_empty)
   );

   // back: walks header, pixel and pad bytes into the output register
   bmp24_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_entry      (q_rd_entry),
      .q_pop        (q_pop),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_data     (rsp_data)
   );

   // a frame always closes on the last byte of its last pixel's run, pad bytes included
   `BMP24_ASSERT_IMPLIES(a_frame_end_last, clock, reset, !rsp_empty && rsp_data.frame_end, rsp_data.run_last, "frame end without run end")

endmodule
